// File: hw/rtl/tcgp_pkg.sv
`default_nettype none

package tcgp_pkg;

   localparam int OP_W       = 2;
   localparam int COL_SPAN_W = 7;
   localparam int ROW_SPAN_W = 12;
   localparam int COLUMN_W   = 7;
   localparam int ROW_W      = 12;
   localparam int TOTAL_W    = 13;

   typedef enum logic [OP_W-1:0] {
      OP_CELL      = 2'd0,
      OP_END_ROW   = 2'd1,
      OP_END_TABLE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // broadcast from the sequencer to every column cell
   typedef struct packed {
      logic                  clear;
      logic                  dec;
      logic                  mark;
      logic [ROW_SPAN_W-1:0] rspan;
   } cell_cmd_type;

endpackage

`default_nettype wire

// File: hw/rtl/tcgp_req_if.sv
`default_nettype none

interface tcgp_req_if;
   import tcgp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [COL_SPAN_W-1:0] col_span;
   logic [ROW_SPAN_W-1:0] row_span;

   modport source (output valid, op, col_span, row_span, input ready);
   modport sink   (input valid, op, col_span, row_span, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcgp_rsp_if.sv
`default_nettype none

interface tcgp_rsp_if;
   import tcgp_pkg::*;

   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] column;
   logic [ROW_W-1:0]    row;
   logic [TOTAL_W-1:0]  total_rows;
   logic                overflow;

   modport source (output valid, column, row, total_rows, overflow, input ready);
   modport sink   (input valid, column, row, total_rows, overflow, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcgp_cell.sv
`default_nettype none

module tcgp_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tcgp_pkg::cell_cmd_type cmd,
   input  wire logic                   mark_en,
   input  wire logic                   tok_load,
   input  wire logic                   tok_start,
   input  wire logic                   tok_in,
   output logic                        tok_out,
   output logic                        hit
);
   import tcgp_pkg::*;

   logic [ROW_SPAN_W-1:0] rows_left_ff, rows_left_in;
   logic                  held_ff, held_in;
   logic                  tok_ff, tok_in_nx;

   always_comb begin
      rows_left_in = rows_left_ff;
      held_in      = held_ff;
      if (cmd.clear) begin
         rows_left_in = '0;
         held_in      = 1'b0;
      end else if (cmd.mark && mark_en) begin
         if (cmd.rspan == '0) begin
            held_in = 1'b1;
         end else begin
            rows_left_in = cmd.rspan;
         end
      end else if (cmd.dec && rows_left_ff != '0) begin
         rows_left_in = rows_left_ff - 1'b1;
      end
   end

   // search token: loaded at the cursor, then handed right each cycle
   assign tok_in_nx = tok_load ? tok_start : tok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_left_ff <= '0;
         held_ff      <= 1'b0;
         tok_ff       <= 1'b0;
      end else begin
         rows_left_ff <= rows_left_in;
         held_ff      <= held_in;
         tok_ff       <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;
   assign hit     = tok_ff && (rows_left_ff != '0 || held_ff);

endmodule

`default_nettype wire

// File: hw/rtl/table_cell_grid_placement.sv
`default_nettype none

// Table cell grid placement. Cells of a table arrive as transfers on req_ch
// (op 0 = cell with col_span/row_span, op 1 = end of row, op 2 = end of
// table) and each produces exactly one transfer on rsp_ch. Every grid column
// is a small cell in a chain holding its remaining row count and a held-to-
// end-of-table flag. A cell item is placed by a search token that starts at
// the cursor column and walks one column per clock through the chain; the
// sequencer keeps the start of the current free run and stops when the run
// is col_span wide (placed) or can no longer fit in MAX_COLS (overflow, no
// state change). End of row and end of table update all columns in
// parallel. One item is in work at a time; the next item is taken as soon
// as its predecessor's result sits in the output register, even if the sink
// has not yet taken it. Reset and end of table clear all column state
// together. Unused op code 3 returns an all-zero result.
module table_cell_grid_placement #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 4096
) (
   input wire logic  clock,
   input wire logic  reset,
   tcgp_req_if.sink  req_ch,
   tcgp_rsp_if.source rsp_ch
);
   import tcgp_pkg::*;

   // column position width (holds MAX_COLS itself)
   localparam int CW = $clog2(MAX_COLS + 1);
   // width of position + span sums
   localparam int SW = ((CW > COL_SPAN_W) ? CW : COL_SPAN_W) + 1;
   // row index width (values up to MAX_ROWS - 1)
   localparam int RW = $clog2(MAX_ROWS);
   // width of row index + row span sums
   localparam int AW = ((RW > ROW_SPAN_W) ? RW : ROW_SPAN_W) + 1;

   localparam logic [SW-1:0] MAX_C    = SW'(MAX_COLS);
   localparam logic [SW-1:0] MAX_C_P1 = SW'(MAX_COLS + 1);
   localparam logic [AW-1:0] ROW_CAP  = AW'(MAX_ROWS - 1);
   localparam logic [RW-1:0] ROW_TOP  = RW'(MAX_ROWS - 1);

   state_type state_ff, state_in;

   // item under work
   op_type                op_ff, op_in;
   logic [COL_SPAN_W-1:0] cspan_ff, cspan_in;
   logic [ROW_SPAN_W-1:0] rspan_ff, rspan_in;
   logic [CW-1:0]         pos_ff, pos_in;      // start of the free run
   logic [CW-1:0]         k_ff, k_in;          // column under the token
   logic [CW-1:0]         ovf_col_ff, ovf_col_in;
   logic                  ovf_ff, ovf_in;

   // table state
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [RW-1:0] row_idx_ff, row_idx_in;
   logic [RW-1:0] last_ff, last_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [TOTAL_W-1:0]  rsp_tot_ff, rsp_tot_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic accept, fire, search_done, tok_load;
   logic [SW-1:0] run_sum, start_sum;
   logic          at_ovf, at_fit;
   logic [MAX_COLS-1:0] tok_vec, hit_vec, mark_vec;
   logic          hit_any;
   cell_cmd_type  cmd;

   // ---------------------------------------------------------------
   // column cell chain
   // ---------------------------------------------------------------
   for (genvar i = 0; i < MAX_COLS; i++) begin : g_col
      logic tok_left;
      if (i == 0) begin : g_first
         assign tok_left = 1'b0;
      end else begin : g_rest
         assign tok_left = tok_vec[i-1];
      end

      // window [pos, pos + col_span) is marked on placement
      assign mark_vec[i] = (SW'(i) >= SW'(pos_ff)) && (SW'(i) < run_sum);

      tcgp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .mark_en   (mark_vec[i]),
         .tok_load  (tok_load),
         .tok_start (cursor_ff == CW'(i)),
         .tok_in    (tok_left),
         .tok_out   (tok_vec[i]),
         .hit       (hit_vec[i])
      );
   end

   assign hit_any = |hit_vec;

   // ---------------------------------------------------------------
   // handshake and search decisions
   // ---------------------------------------------------------------
   assign accept    = req_ch.valid && req_ch.ready;
   assign fire      = !rsp_valid_ff || rsp_ch.ready;
   assign run_sum   = SW'(pos_ff) + SW'(cspan_ff);
   assign start_sum = SW'(cursor_ff) + SW'(req_ch.col_span);
   assign at_ovf    = run_sum > MAX_C;
   assign at_fit    = SW'(k_ff) == run_sum;
   assign search_done = at_ovf || at_fit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_ch.op) == OP_CELL) ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (search_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ch.ready = 1'b0;
      tok_load     = 1'b0;
      cmd          = '{clear: 1'b0, dec: 1'b0, mark: 1'b0, rspan: rspan_ff};
      case (state_ff)
         ST_IDLE: begin
            // no transfer is taken while reset is held
            req_ch.ready = !reset;
            tok_load     = 1'b1;
         end
         ST_SEARCH: begin
         end
         ST_FINISH: begin
            if (fire) begin
               case (op_ff)
                  OP_CELL:      cmd.mark  = !ovf_ff && (rspan_ff != ROW_SPAN_W'(1));
                  OP_END_ROW:   cmd.dec   = 1'b1;
                  OP_END_TABLE: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------
   logic [AW-1:0]    raise_val, raise_cap;
   logic [RW-1:0]    raise_row;
   logic [RW:0]      tot_cand;
   logic [RW:0]      tot_val;

   always_comb begin
      // highest row reached: row_index + row_span - 1 for a cell,
      // the row just completed for end of row; saturates
      if (op_ff == OP_CELL) begin
         raise_val = AW'(row_idx_ff) + AW'(rspan_ff) - AW'(1);
      end else begin
         raise_val = AW'(row_idx_ff);
      end
      raise_cap = (raise_val > ROW_CAP) ? ROW_CAP : raise_val;
      raise_row = RW'(raise_cap);

      tot_cand = (RW + 1)'(last_ff) + (RW + 1)'(1);
      tot_val  = ((RW + 1)'(row_idx_ff) > tot_cand) ? (RW + 1)'(row_idx_ff) : tot_cand;
      if (tot_val > (RW + 1)'(MAX_ROWS)) begin
         tot_val = (RW + 1)'(MAX_ROWS);
      end
   end

   always_comb begin
      op_in      = op_ff;
      cspan_in   = cspan_ff;
      rspan_in   = rspan_ff;
      pos_in     = pos_ff;
      k_in       = k_ff;
      ovf_col_in = ovf_col_ff;
      ovf_in     = ovf_ff;
      cursor_in  = cursor_ff;
      row_idx_in = row_idx_ff;
      last_in    = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_col_in = rsp_col_ff;
      rsp_row_in = rsp_row_ff;
      rsp_tot_in = rsp_tot_ff;
      rsp_ovf_in = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_ch.op);
               cspan_in = req_ch.col_span;
               rspan_in = req_ch.row_span;
               pos_in   = cursor_ff;
               k_in     = cursor_ff;
               ovf_in   = 1'b0;
               // first position whose window passes capacity
               if (start_sum > MAX_C) begin
                  ovf_col_in = cursor_ff;
               end else begin
                  ovf_col_in = CW'(MAX_C_P1 - SW'(req_ch.col_span));
               end
            end
         end
         ST_SEARCH: begin
            if (at_ovf) begin
               ovf_in = 1'b1;
               pos_in = ovf_col_ff;
            end else if (!at_fit) begin
               if (hit_any) begin
                  pos_in = k_ff + 1'b1;
               end
               k_in = k_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = '0;
               rsp_row_in   = '0;
               rsp_tot_in   = '0;
               rsp_ovf_in   = 1'b0;
               case (op_ff)
                  OP_CELL: begin
                     rsp_col_in = COLUMN_W'(pos_ff);
                     rsp_row_in = ROW_W'(row_idx_ff);
                     rsp_ovf_in = ovf_ff;
                     if (!ovf_ff) begin
                        cursor_in = CW'(run_sum);
                        if (rspan_ff != '0 && raise_row > last_ff) begin
                           last_in = raise_row;
                        end
                     end
                  end
                  OP_END_ROW: begin
                     rsp_row_in = ROW_W'(row_idx_ff);
                     if (raise_row > last_ff) begin
                        last_in = raise_row;
                     end
                     if (row_idx_ff != ROW_TOP) begin
                        row_idx_in = row_idx_ff + 1'b1;
                     end
                     cursor_in = '0;
                  end
                  OP_END_TABLE: begin
                     rsp_tot_in = TOTAL_W'(tot_val);
                     rsp_row_in = ROW_W'(tot_val - (RW + 1)'(1));
                     cursor_in  = '0;
                     row_idx_in = '0;
                     last_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         row_idx_ff   <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         row_idx_ff   <= row_idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      cspan_ff   <= cspan_in;
      rspan_ff   <= rspan_in;
      pos_ff     <= pos_in;
      k_ff       <= k_in;
      ovf_col_ff <= ovf_col_in;
      ovf_ff     <= ovf_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_tot_ff <= rsp_tot_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.column     = rsp_col_ff;
   assign rsp_ch.row        = rsp_row_ff;
   assign rsp_ch.total_rows = rsp_tot_ff;
   assign rsp_ch.overflow   = rsp_ovf_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> $onehot0(tok_vec))
      else $error("search token duplicated in cell chain");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && !at_ovf) |-> (pos_ff <= k_ff && SW'(k_ff) <= run_sum))
      else $error("token left the current free run");

   a_cursor_cap: assert property (@(posedge clock) disable iff (reset)
      SW'(cursor_ff) <= MAX_C)
      else $error("cursor past column capacity");

   a_short_op: assert property (@(posedge clock) disable iff (reset)
      (accept && op_type'(req_ch.op) != OP_CELL) |=> state_ff == ST_FINISH)
      else $error("non-cell item entered search");

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcgp_pkg::*;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 4096;

   // op code that the block ignores; it still answers with an all-zero transfer
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic [TOTAL_W-1:0]  total_rows;
      logic                overflow;
   } grid_result_type;

   class placement_scoreboard;
      bit [ROW_SPAN_W-1:0] rows_left [GRID_COLS];
      bit                  held [GRID_COLS];
      int                  cursor;
      int                  row_index;
      int                  last_row;
      grid_result_type     pending [$];
      int                  errors;

      function void clear_grid();
         for (int k = 0; k < GRID_COLS; k++) begin
            rows_left[k] = '0;
            held[k] = 1'b0;
         end
         cursor = 0;
         row_index = 0;
         last_row = 0;
      endfunction

      function void raise_last(int r);
         if (r > GRID_ROWS - 1) r = GRID_ROWS - 1;
         if (r > last_row) last_row = r;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [COL_SPAN_W-1:0] cspan,
                                 logic [ROW_SPAN_W-1:0] rspan);
         grid_result_type exp;
         int              pos;
         int              cs;
         int              t;
         bit              placed;
         bit              hit;
         exp = '0;
         cs = cspan;
         case (op)
            OP_CELL: begin
               pos = cursor;
               placed = 1'b0;
               // slide right until the whole window is free or no longer fits
               while (!placed && pos + cs <= GRID_COLS) begin
                  hit = 1'b0;
                  for (int k = pos; k < pos + cs; k++)
                     if (rows_left[k] != 0 || held[k]) hit = 1'b1;
                  if (hit) pos++;
                  else placed = 1'b1;
               end
               exp.column = pos[COLUMN_W-1:0];
               exp.row = row_index[ROW_W-1:0];
               if (!placed) begin
                  exp.overflow = 1'b1;
               end else begin
                  if (rspan != 1) begin
                     for (int k = pos; k < pos + cs && k < GRID_COLS; k++) begin
                        if (rspan == 0) held[k] = 1'b1;
                        else rows_left[k] = rspan;
                     end
                  end
                  if (rspan != 0) raise_last(row_index + int'(rspan) - 1);
                  cursor = pos + cs;
               end
            end
            OP_END_ROW: begin
               exp.row = row_index[ROW_W-1:0];
               raise_last(row_index);
               if (row_index < GRID_ROWS - 1) row_index++;
               for (int k = 0; k < GRID_COLS; k++)
                  if (rows_left[k] != 0) rows_left[k]--;
               cursor = 0;
            end
            OP_END_TABLE: begin
               t = last_row + 1;
               if (row_index > t) t = row_index;
               if (t > GRID_ROWS) t = GRID_ROWS;
               exp.total_rows = t[TOTAL_W-1:0];
               exp.row = ROW_W'(t - 1);
               clear_grid();
            end
            default: ;
         endcase
         pending.push_back(exp);
      endfunction

      function void check_result(grid_result_type got);
         grid_result_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: column=%0d row=%0d total_rows=%0d ovf=%0b",
                        got.column, got.row, got.total_rows, got.overflow);
         end else begin
            exp = pending.pop_front();
            if (exp.column !== got.column || exp.row !== got.row ||
                exp.total_rows !== got.total_rows || exp.overflow !== got.overflow) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp col=%0d row=%0d tot=%0d ovf=%0b,",
                            " got col=%0d row=%0d tot=%0d ovf=%0b"},
                           exp.column, exp.row, exp.total_rows, exp.overflow,
                           got.column, got.row, got.total_rows, got.overflow);
            end
         end
      endfunction
   endclass

   // generous bound: every item at worst-case search plus both sides' longest gaps
   localparam int CYCLE_LIMIT = 500_000;
   localparam int RANDOM_ITEMS = 780;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   sent_items = 0;
   bit   calm_tx = 1'b0;
   bit   calm_rx = 1'b0;

   placement_scoreboard sb;

   tcgp_req_if req_ch ();
   tcgp_rsp_if rsp_ch ();

   table_cell_grid_placement #(
      .MAX_COLS (GRID_COLS),
      .MAX_ROWS (GRID_ROWS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One input transfer. Called at a rising edge; returns at the edge of the
   // transfer. valid is lowered only when a gap follows, so it never gets two
   // assignments in the same step.
   task automatic send_item(input logic [OP_W-1:0] op, input int cs, input int rs);
      int gap;
      gap = calm_tx ? 0 : $urandom_range(0, 12);
      // flip between idle-free stretches and random gaps now and then
      if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.col_span <= cs[COL_SPAN_W-1:0];
      req_ch.row_span <= rs[ROW_SPAN_W-1:0];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(op, cs[COL_SPAN_W-1:0], rs[ROW_SPAN_W-1:0]);
      if (op != OP_UNUSED) sent_items++;
   endtask

   // Result side: random back-pressure per transfer, checked at the edge.
   task automatic drain_results();
      int              gap;
      grid_result_type got;
      forever begin
         gap = calm_rx ? 0 : $urandom_range(0, 12);
         if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.column     = rsp_ch.column;
         got.row        = rsp_ch.row;
         got.total_rows = rsp_ch.total_rows;
         got.overflow   = rsp_ch.overflow;
         sb.check_result(got);
      end
   endtask

   initial begin
      int start;
      int rows;
      int cells;
      int pick;
      int cs;
      int rs;

      sb = new();
      sb.clear_grid();

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_CELL;
      req_ch.col_span <= '0;
      req_ch.row_span <= '0;
      rsp_ch.ready    <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      fork
         drain_results();
      join_none

      // ---- directed part ----
      // empty table: one row reported
      send_item(OP_END_TABLE, 0, 0);
      // single-row cell marks nothing
      send_item(OP_CELL, 1, 1);
      // zero-width cell: placed at cursor, no check, cursor stays
      send_item(OP_CELL, 0, 5);
      send_item(OP_CELL, 3, 2);
      // held to end of table
      send_item(OP_CELL, 2, 0);
      // window runs past the last column
      send_item(OP_CELL, 64, 1);
      send_item(OP_END_ROW, 64, 4095);
      // search must walk over spans carried down from the row above
      send_item(OP_CELL, 1, 1);
      send_item(OP_CELL, 4, 3);
      send_item(OP_CELL, 1, 2);
      send_item(OP_END_ROW, 0, 0);
      send_item(OP_END_TABLE, 127 & 64, 2048);
      // full-width cell, tall span; cursor ends at the last column + 1
      send_item(OP_CELL, 64, 4095);
      send_item(OP_CELL, 0, 0);
      // unused op with busy fields is ignored
      send_item(OP_UNUSED, 64, 4095);
      send_item(OP_END_ROW, 0, 0);
      // every column still busy
      send_item(OP_CELL, 64, 1);
      send_item(OP_CELL, 1, 1);
      send_item(OP_END_TABLE, 0, 0);
      // span reaching past the row limit saturates the count
      send_item(OP_END_ROW, 0, 0);
      send_item(OP_END_ROW, 0, 0);
      send_item(OP_CELL, 5, 4095);
      send_item(OP_END_TABLE, 0, 0);

      // ---- random tables ----
      // mostly well-formed rows of cells; some noise, missing row ends and
      // tables cut short by a random end
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS) begin
         rows = $urandom_range(1, 8);
         for (int r = 0; r < rows; r++) begin
            cells = $urandom_range(0, 8);
            for (int c = 0; c < cells; c++) begin
               pick = $urandom_range(0, 99);
               if (pick < 4) begin
                  send_item(OP_UNUSED, $urandom_range(0, 64), $urandom_range(0, 4095));
               end else begin
                  pick = $urandom_range(0, 99);
                  if (pick < 10) cs = 0;
                  else if (pick < 70) cs = $urandom_range(1, 4);
                  else if (pick < 88) cs = $urandom_range(5, 16);
                  else cs = $urandom_range(17, 64);
                  pick = $urandom_range(0, 99);
                  if (pick < 8) rs = 0;
                  else if (pick < 60) rs = $urandom_range(1, 3);
                  else if (pick < 90) rs = $urandom_range(4, 12);
                  else rs = $urandom_range(0, 4095);
                  send_item(OP_CELL, cs, rs);
               end
            end
            if ($urandom_range(0, 9) != 0)
               send_item(OP_END_ROW, $urandom_range(0, 64), $urandom_range(0, 4095));
         end
         send_item(OP_END_TABLE, $urandom_range(0, 64), $urandom_range(0, 4095));
      end
      req_ch.valid <= 1'b0;

      // drain, then linger in case the block emits anything extra
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (GRID_COLS + 8) @(posedge clock);

      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// File: sim.f
hw/rtl/tcgp_pkg.sv
hw/rtl/tcgp_req_if.sv
hw/rtl/tcgp_rsp_if.sv
hw/rtl/tcgp_cell.sv
hw/rtl/table_cell_grid_placement.sv
tb/testbench.sv
